// ===== rtl/core/pcscan_pkg.sv =====
package pcscan_pkg;

   // stream and field widths
   localparam int BYTE_W     = 8;
   localparam int WIDTH_W    = 6;
   localparam int MATCH_W    = 32;
   localparam int COUNT_W    = 25;
   localparam int LEAD_W     = 16;
   localparam int WORD_W     = 64;
   localparam int POS_W      = 6;
   localparam int INDEX_W    = 18;
   localparam int ACC_W      = 40;
   localparam int HELD_W     = 6;
   localparam int SHIFT_W    = 11;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_IDX_W  = 2;

   // entries that one byte can finish at most: up to 31 held bits plus the
   // byte, at width one once entry_width is lowered in the middle of a scan
   localparam int LANES      = 39;
   localparam int LANE_CNT_W = 6;

   // longest column that is scanned
   localparam logic [31:0] MAX_ENTRIES = 32'd16777216;

   // reset value of entry_width, and the widest entry
   localparam logic [WIDTH_W-1:0] RESET_ENTRY_WIDTH = 6'd8;
   localparam logic [WIDTH_W-1:0] MAX_ENTRY_WIDTH   = 6'd32;

   // result queue
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = 2;
   localparam int OUTQ_CNT_W = 3;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENTRY_WIDTH = 2'd0,
      REG_MATCH_VALUE = 2'd1,
      REG_ENTRY_COUNT = 2'd2,
      REG_LEAD_BYTES  = 2'd3
   } csr_reg_type;

   // one bitmap word on its way out
   typedef struct packed {
      logic                last_word;
      logic [INDEX_W-1:0]  word_index;
      logic [WORD_W-1:0]   bitmap_word;
   } rsp_item_type;

   // what the unpacker makes of one byte
   typedef struct packed {
      logic [LANES-1:0]      hits;
      logic [LANE_CNT_W-1:0] cnt;
      logic [ACC_W-1:0]      acc_rest;
      logic [HELD_W-1:0]     held_rest;
   } unpack_res_type;

endpackage

// ===== rtl/core/pcscan_unpack.sv =====
module pcscan_unpack
   import pcscan_pkg::*;
(
   input  logic [ACC_W-1:0]   acc,
   input  logic [HELD_W-1:0]  held,
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic [WIDTH_W-1:0] eff_w,
   input  logic [MATCH_W-1:0] mask,
   input  logic [MATCH_W-1:0] target,
   input  logic [COUNT_W-1:0] remaining,
   output unpack_res_type     res
);

   logic [ACC_W-1:0]      acc_all;
   logic [HELD_W-1:0]     held_all;
   logic [LANES-1:0]      lane_ok;
   logic [LANES-1:0]      lane_eq;
   logic [LANE_CNT_W-1:0] cnt;
   logic [SHIFT_W-1:0]    used_bits;

   // new byte lands above the held bits
   assign acc_all  = acc | (ACC_W'(data_byte) << held);
   assign held_all = held + HELD_W'(BYTE_W);

   // one lane per entry that this byte may finish, each at its own offset
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic [SHIFT_W-1:0] offs;
      logic [SHIFT_W-1:0] ends;
      logic [ACC_W-1:0]   shifted;

      assign offs    = SHIFT_W'(eff_w) * SHIFT_W'(k);
      assign ends    = SHIFT_W'(eff_w) * SHIFT_W'(k + 1);
      assign shifted = acc_all >> offs;
      assign lane_ok[k] = (SHIFT_W'(held_all) >= ends) && (remaining > COUNT_W'(k));
      assign lane_eq[k] = (shifted[MATCH_W-1:0] & mask) == target;
   end

   // valid lanes form a prefix, so the count is one past the last valid lane
   always_comb begin
      cnt = '0;
      for (int k = 0; k < LANES; k++) begin
         if (lane_ok[k]) begin
            cnt = LANE_CNT_W'(k + 1);
         end
      end
   end

   assign used_bits = SHIFT_W'(cnt) * SHIFT_W'(eff_w);

   assign res.hits      = lane_ok & lane_eq;
   assign res.cnt       = cnt;
   assign res.acc_rest  = acc_all >> used_bits;
   assign res.held_rest = held_all - HELD_W'(used_bits);

endmodule

// ===== rtl/core/pcscan_outq.sv =====
module pcscan_outq
   import pcscan_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_a,
   input  logic                  push_b,
   input  rsp_item_type          item_a,
   input  rsp_item_type          item_b,
   output logic                  room_two,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   rsp_item_type              slot_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_W-1:0]     count_ff, count_in;
   logic [OUTQ_PTR_W-1:0]     wr_next;
   logic [OUTQ_CNT_W-1:0]     push_cnt;
   logic                      pop;
   rsp_item_type              head;

   assign wr_next  = wr_ptr_ff + OUTQ_PTR_W'(1);
   assign push_cnt = OUTQ_CNT_W'(push_a) + OUTQ_CNT_W'(push_b);
   assign pop      = rsp_tvalid && rsp_tready;
   assign room_two = count_ff <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + OUTQ_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + OUTQ_PTR_W'(pop);
      count_in  = count_ff + push_cnt - OUTQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // up to two words written per cycle, in order
   always_ff @(posedge clock) begin
      if (push_a) begin
         slot_ff[wr_ptr_ff] <= item_a;
      end
      if (push_b) begin
         slot_ff[wr_next] <= item_b;
      end
   end

   // head of the queue drives the result channel
   assign head       = slot_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {(RSP_DATA_W - WORD_W - INDEX_W)'(0), head.word_index, head.bitmap_word};
   assign rsp_tlast  = head.last_word;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OUTQ_CNT_W'(OUTQ_DEPTH))
      else $error("result queue fill above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != '0) |-> (push_cnt <= OUTQ_CNT_W'(OUTQ_DEPTH) - count_ff))
      else $error("result queue written while full");

   a_b_after_a: assert property (@(posedge clock) disable iff (reset)
      push_b |-> push_a)
      else $error("second word pushed without first");
`endif

endmodule

// ===== rtl/core/packed_column_equality_scan_core.sv =====
// Packed column equality scan.
// req_ carries the column one byte per beat (req_tdata). Entries are packed
// lsb first, entry_width bits each; the first lead_bytes beats are dropped.
// Every entry is compared with match_value and its result set in a 64-bit
// bitmap word, sent on rsp_ when 64 entries are done or when the last of
// entry_count entries is done (rsp_tlast marks that final word). Beats after
// the final entry are taken and give nothing.
// csr_ writes one register per cycle (0 entry_width, 1 match_value,
// 2 entry_count, 3 lead_bytes); write only while the block is idle.
// A word finished by a beat is written into a 4-deep queue when the beat,
// held in the input register, passes the compare step with room in the queue;
// rsp_tvalid then rises from the queue's registered fill count.
// One beat is taken per cycle while the queue has room; up to eight entries
// are compared per beat in a steady scan, up to 39 right after entry_width
// is lowered mid-scan. Only the beat that ends the scan can end two words
// (a full word and the final one); both go into the queue together.
// When rsp_tready is low the queue fills; with fewer than two free slots the
// byte waits in the input register and req_tready drops.
// Reset (synchronous) restores register defaults and starts a new scan.
module packed_column_equality_scan_core
   import pcscan_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [7:0] data_byte
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,
   // rsp_tdata: [63:0] bitmap_word, [81:64] word_index, [87:82] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [MATCH_W-1:0]    csr_wdata
);

   // configuration
   logic [WIDTH_W-1:0] entry_width_ff;
   logic [MATCH_W-1:0] match_value_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [LEAD_W-1:0]  lead_bytes_ff;

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]  s1_byte_ff;

   // scan state
   logic [LEAD_W-1:0]  lead_counter_ff, lead_counter_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [COUNT_W-1:0] done_ff, done_in;
   logic [WORD_W-1:0]  word_bits_ff, word_bits_in;

   logic [WIDTH_W-1:0]   eff_w;
   logic [MATCH_W-1:0]   mask;
   logic [MATCH_W-1:0]   target;
   logic [COUNT_W-1:0]   limit;
   logic                 room_two;
   logic                 proc;
   logic                 skip;
   logic                 active;
   unpack_res_type       ures;
   logic [2*WORD_W-1:0]  merged;
   logic [POS_W:0]       end_pos;
   logic                 full;
   logic [COUNT_W-1:0]   new_done;
   logic                 fin;
   logic [INDEX_W-1:0]   idx_a;
   logic                 push_a, push_b;
   rsp_item_type         item_a, item_b;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_width_ff <= RESET_ENTRY_WIDTH;
         match_value_ff <= '0;
         entry_count_ff <= '0;
         lead_bytes_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_ENTRY_WIDTH: entry_width_ff <= csr_wdata[WIDTH_W-1:0];
            REG_MATCH_VALUE: match_value_ff <= csr_wdata;
            REG_ENTRY_COUNT: entry_count_ff <= csr_wdata[COUNT_W-1:0];
            REG_LEAD_BYTES:  lead_bytes_ff  <= csr_wdata[LEAD_W-1:0];
         endcase
      end
   end

   // effective width, mask and entry limit
   always_comb begin
      if (entry_width_ff == '0) begin
         eff_w = WIDTH_W'(1);
      end else if (entry_width_ff > MAX_ENTRY_WIDTH) begin
         eff_w = MAX_ENTRY_WIDTH;
      end else begin
         eff_w = entry_width_ff;
      end
      mask   = {MATCH_W{1'b1}} >> (MAX_ENTRY_WIDTH - eff_w);
      target = match_value_ff & mask;
      limit  = (32'(entry_count_ff) > MAX_ENTRIES) ? MAX_ENTRIES[COUNT_W-1:0]
                                                    : entry_count_ff;
   end

   // input register and handshake
   assign proc        = s1_valid_ff && room_two;
   assign req_tready  = !s1_valid_ff || proc;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !proc);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
      end
   end

   // entry lanes
   pcscan_unpack u_unpack (
      .acc       (acc_ff),
      .held      (held_ff),
      .data_byte (s1_byte_ff),
      .eff_w     (eff_w),
      .mask      (mask),
      .target    (target),
      .remaining (limit - done_ff),
      .res       (ures)
   );

   // merge hits into the current word and decide what goes out
   always_comb begin
      skip     = lead_counter_ff < lead_bytes_ff;
      active   = proc && !skip && (done_ff < limit);
      merged   = {{WORD_W{1'b0}}, word_bits_ff}
               | ((2*WORD_W)'(ures.hits) << done_ff[POS_W-1:0]);
      end_pos  = {1'b0, done_ff[POS_W-1:0]} + (POS_W+1)'(ures.cnt);
      full     = end_pos[POS_W];
      new_done = done_ff + COUNT_W'(ures.cnt);
      fin      = new_done == limit;
      idx_a    = done_ff[POS_W +: INDEX_W];

      push_a = active && (full || fin);
      push_b = active && full && fin && (end_pos[POS_W-1:0] != '0);

      item_a.bitmap_word = merged[WORD_W-1:0];
      item_a.word_index  = idx_a;
      item_a.last_word   = fin && !push_b;
      item_b.bitmap_word = merged[2*WORD_W-1:WORD_W];
      item_b.word_index  = idx_a + INDEX_W'(1);
      item_b.last_word   = 1'b1;

      lead_counter_in = lead_counter_ff;
      acc_in          = acc_ff;
      held_in         = held_ff;
      done_in         = done_ff;
      word_bits_in    = word_bits_ff;
      if (proc && skip) begin
         lead_counter_in = lead_counter_ff + LEAD_W'(1);
      end
      if (active) begin
         done_in = new_done;
         if (fin) begin
            acc_in       = '0;
            held_in      = '0;
            word_bits_in = '0;
         end else begin
            acc_in       = ures.acc_rest;
            held_in      = ures.held_rest;
            word_bits_in = full ? merged[2*WORD_W-1:WORD_W] : merged[WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_counter_ff <= '0;
         acc_ff          <= '0;
         held_ff         <= '0;
         done_ff         <= '0;
         word_bits_ff    <= '0;
      end else begin
         lead_counter_ff <= lead_counter_in;
         acc_ff          <= acc_in;
         held_ff         <= held_in;
         done_ff         <= done_in;
         word_bits_ff    <= word_bits_in;
      end
   end

   // result queue
   pcscan_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_a     (push_a),
      .push_b     (push_b),
      .item_a     (item_a),
      .item_b     (item_b),
      .room_two   (room_two),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push_b |-> (!item_a.last_word && item_b.word_index == idx_a + INDEX_W'(1)))
      else $error("two words from one beat out of order");

   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      (active && fin) |=> (word_bits_ff == '0 && held_ff == '0 && acc_ff == '0))
      else $error("state not cleared at end of scan");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !proc) |=> (s1_valid_ff && $stable(s1_byte_ff)))
      else $error("waiting byte lost");

   a_no_words_in_skip: assert property (@(posedge clock) disable iff (reset)
      (proc && skip) |-> (!push_a && done_in == done_ff))
      else $error("word produced while dropping lead bytes");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import pcscan_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   // req_tdata: [7:0] data_byte
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   // rsp_tdata: [63:0] bitmap_word, [81:64] word_index, [87:82] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [MATCH_W-1:0]    csr_wdata = '0;

   // register mirror
   logic [WIDTH_W-1:0] col_width = RESET_ENTRY_WIDTH;
   logic [MATCH_W-1:0] col_match = '0;
   logic [COUNT_W-1:0] col_count = '0;
   logic [LEAD_W-1:0]  col_lead  = '0;

   // scan progress as the predictor sees it
   logic [LEAD_W-1:0]  drop_seen    = '0;
   logic [ACC_W-1:0]   pend_bits    = '0;
   logic [HELD_W-1:0]  pend_cnt     = '0;
   logic [COUNT_W-1:0] entries_seen = '0;
   logic [WORD_W-1:0]  cur_word     = '0;

   rsp_item_type bitmap_words_due[$];
   int mismatch_count = 0;
   int cycle_count    = 0;
   int beats_sent     = 0;

   // idling control
   bit idle_on    = 1'b0;
   int hold_req   = 0;
   int hold_left  = 0;
   int stall_left = 0;

   // column generator: packs entries lsb first into bytes
   logic [63:0] gen_stage = '0;
   int          gen_bits  = 0;
   bit          gen_noise = 1'b0;

   packed_column_equality_scan_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int unsigned active_width();
      if (col_width == 0) return 1;
      if (col_width > MAX_ENTRY_WIDTH) return MAX_ENTRY_WIDTH;
      return col_width;
   endfunction

   function automatic logic [COUNT_W-1:0] active_count();
      if (col_count > MAX_ENTRIES) return MAX_ENTRIES[COUNT_W-1:0];
      return col_count;
   endfunction

   function automatic logic [31:0] width_mask(input int unsigned w);
      return 32'((64'd1 << w) - 64'd1);
   endfunction

   function automatic logic [31:0] lead_after(input int extra);
      int total;
      total = int'(drop_seen) + extra;
      if (total > (1 << LEAD_W) - 1) return (1 << LEAD_W) - 1;
      return 32'(total);
   endfunction

   // unpack one accepted byte and queue the bitmap words it completes
   task automatic predict_bitmap_words(input logic [BYTE_W-1:0] b);
      int unsigned        w;
      logic [COUNT_W-1:0] lim;
      logic [31:0]        msk;
      logic [POS_W-1:0]   pos;
      rsp_item_type       item;
      w   = active_width();
      lim = active_count();
      msk = width_mask(w);
      // leading bytes go first
      if (drop_seen < col_lead) begin
         drop_seen = drop_seen + 1'b1;
         return;
      end
      if (entries_seen >= lim) return;
      pend_bits = pend_bits | (ACC_W'(b) << pend_cnt);
      pend_cnt  = pend_cnt + HELD_W'(BYTE_W);
      while (pend_cnt >= w && entries_seen < lim) begin
         pos = entries_seen[POS_W-1:0];
         if ((pend_bits[31:0] & msk) == (col_match & msk)) cur_word[pos] = 1'b1;
         pend_bits    = pend_bits >> w;
         pend_cnt     = pend_cnt - HELD_W'(w);
         entries_seen = entries_seen + 1'b1;
         // word full or scan done
         if (&pos || entries_seen == lim) begin
            item.bitmap_word = cur_word;
            item.word_index  = INDEX_W'((entries_seen - 1'b1) >> 6);
            item.last_word   = (entries_seen == lim);
            bitmap_words_due.push_back(item);
            cur_word = '0;
         end
      end
      // leftover bits are dropped once the scan is done
      if (entries_seen >= lim) begin
         pend_bits = '0;
         pend_cnt  = '0;
      end
   endtask

   // compare each bitmap word beat with the oldest expected one
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (bitmap_words_due.size() == 0) begin
            $display("%0t unexpected bitmap word: expected none, actual %h index %0d last %b",
                     $time, rsp_tdata[WORD_W-1:0], rsp_tdata[WORD_W +: INDEX_W], rsp_tlast);
            mismatch_count++;
         end else begin
            want = bitmap_words_due.pop_front();
            if (rsp_tdata[WORD_W-1:0] !== want.bitmap_word) begin
               $display("%0t bitmap_word mismatch: expected %h actual %h",
                        $time, want.bitmap_word, rsp_tdata[WORD_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[WORD_W +: INDEX_W] !== want.word_index) begin
               $display("%0t word_index mismatch: expected %0d actual %0d",
                        $time, want.word_index, rsp_tdata[WORD_W +: INDEX_W]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last_word) begin
               $display("%0t last_word mismatch: expected %b actual %b",
                        $time, want.last_word, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // receiver: long hold on request, else random stall bursts
   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one column byte; returns at the edge where it is taken
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      predict_bitmap_words(b);
   endtask

   task automatic next_column_byte(output logic [BYTE_W-1:0] b);
      int unsigned w;
      logic [31:0] e;
      w = active_width();
      if (gen_noise) begin
         b = BYTE_W'($urandom);
         return;
      end
      // mostly hits, some one-bit misses, some random entries
      while (gen_bits < 8) begin
         case ($urandom_range(0, 3))
            0, 1:    e = col_match;
            2:       e = col_match ^ (32'd1 << $urandom_range(0, w - 1));
            default: e = $urandom;
         endcase
         gen_stage = gen_stage | (64'(e & width_mask(w)) << gen_bits);
         gen_bits += w;
      end
      b = gen_stage[7:0];
      gen_stage = gen_stage >> 8;
      gen_bits -= 8;
   endtask

   // register write with random bits above the field
   task automatic write_reg(input csr_reg_type r, input logic [31:0] v);
      logic [31:0] keep;
      case (r)
         REG_ENTRY_WIDTH: begin
            keep = 32'((64'd1 << WIDTH_W) - 1);
            col_width = v[WIDTH_W-1:0];
         end
         REG_MATCH_VALUE: begin
            keep = '1;
            col_match = v;
         end
         REG_ENTRY_COUNT: begin
            keep = 32'((64'd1 << COUNT_W) - 1);
            col_count = v[COUNT_W-1:0];
         end
         REG_LEAD_BYTES: begin
            keep = 32'((64'd1 << LEAD_W) - 1);
            col_lead = v[LEAD_W-1:0];
         end
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= r;
      csr_wdata <= (v & keep) | (32'($urandom) & ~keep);
   endtask

   task automatic configure(input logic [31:0] width_raw, match, count_raw, lead);
      write_reg(REG_ENTRY_WIDTH, width_raw);
      write_reg(REG_MATCH_VALUE, match);
      write_reg(REG_ENTRY_COUNT, count_raw);
      write_reg(REG_LEAD_BYTES, lead);
      @(negedge clock) csr_wr_en <= 1'b0;
      gen_stage = '0;
      gen_bits  = 0;
   endtask

   // feed bytes until the lead is gone and the scan (or stop point) is reached
   task automatic feed_column(input logic [31:0] stop_at);
      logic [BYTE_W-1:0] b;
      while (drop_seen < col_lead ||
             (entries_seen < active_count() && entries_seen < stop_at)) begin
         if (drop_seen < col_lead) b = BYTE_W'($urandom);
         else next_column_byte(b);
         send_byte(b);
      end
   endtask

   // sender quiet, all words back, then a wait for work still inside
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (bitmap_words_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic scan_phase(input logic [31:0] width_raw, match,
                             input int entries, lead_extra);
      configure(width_raw, match, entries_seen + entries, lead_after(lead_extra));
      feed_column('1);
      // bytes after the final entry give nothing
      repeat ($urandom_range(0, 2)) send_byte(BYTE_W'($urandom));
      drain();
   endtask

   // count of zero after reset: nothing comes out
   task automatic test_empty_scan();
      repeat (6) send_byte(BYTE_W'($urandom));
      drain();
   endtask

   task automatic test_byte_extremes();
      logic [BYTE_W-1:0] pattern [12];
      pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hFE, 8'h7F,
                  8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFF, 8'hFF};
      // match value wider than the entry is masked
      configure(8, 32'hFFFF_FFFF, entries_seen + 12, lead_after(3));
      repeat (3) send_byte(BYTE_W'($urandom));
      foreach (pattern[i]) send_byte(pattern[i]);
      send_byte(8'hFF);
      drain();
   endtask

   task automatic test_width_limits();
      scan_phase(32, 32'hFFFF_FFFF, 5, 0);
      scan_phase(32, 32'h0, 3, 1);
      // width zero acts as one; scan ends exactly on a word boundary
      scan_phase(0, 32'h1, 128 - int'(entries_seen[POS_W-1:0]), 0);
      // widths above 32 act as 32
      scan_phase(6'h3F, $urandom, 4, 0);
      scan_phase(33, $urandom, 4, 0);
      scan_phase(31, $urandom, 5, 0);
      scan_phase(1, 32'h0, 20, 0);
   endtask

   // one byte that ends a word and the scan
   task automatic test_two_words_one_beat();
      int n;
      n = ((12 - int'(entries_seen) % 8) % 8) + 8;
      scan_phase(1, $urandom, n, 0);
      n = ((int'(entries_seen) >> 6) + 1) * 64 + 2 - int'(entries_seen);
      scan_phase(1, $urandom, n, 0);
   endtask

   // count above the limit, then cut short with a new count
   task automatic test_count_clamp();
      configure(5, $urandom, 32'h01FF_FFFF, lead_after(0));
      feed_column(entries_seen + 64);
      drain();
      configure(5, col_match, entries_seen + 7, lead_after(0));
      feed_column('1);
      drain();
   endtask

   task automatic test_random_scans(input int budget, input bit allow_idle);
      int start, w, ew, n;
      start = beats_sent;
      while (beats_sent - start < budget) begin
         idle_on = allow_idle && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
         else w = $urandom_range(1, 32);
         ew = (w == 0) ? 1 : (w > 32) ? 32 : w;
         n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 480 / ew);
         gen_noise = ($urandom_range(0, 3) == 0);
         scan_phase(w, $urandom, n, $urandom_range(0, 4));
      end
      gen_noise = 1'b0;
      idle_on   = allow_idle;
   endtask

   // receiver holds off while the sender keeps pushing narrow entries
   task automatic test_output_hold();
      idle_on  = 1'b0;
      hold_req = 300;
      scan_phase(1, $urandom, 320, 0);
      idle_on = 1'b1;
   endtask

   // sender waits for every word mid-scan, match value changes, scan goes on
   task automatic test_sender_pause();
      configure(7, $urandom, entries_seen + 64, lead_after(2));
      feed_column(entries_seen + 30);
      drain();
      write_reg(REG_MATCH_VALUE, $urandom);
      @(negedge clock) csr_wr_en <= 1'b0;
      feed_column('1);
      drain();
   endtask

   // lead bytes dropped again before a continued scan
   task automatic test_lead_limit();
      idle_on = 1'b0;
      configure(12, $urandom, entries_seen + 24, lead_after(5));
      feed_column('1);
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      idle_on = 1'b1;
      test_empty_scan();
      test_byte_extremes();
      test_width_limits();
      test_two_words_one_beat();
      test_count_clamp();
      test_random_scans(60, 1'b1);
      test_output_hold();
      test_sender_pause();
      test_lead_limit();
      // closing stretch without idling
      test_random_scans(30, 1'b0);
      repeat (20) @(posedge clock);
      if (bitmap_words_due.size() != 0) begin
         $display("%0t %0d bitmap words never arrived", $time, bitmap_words_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pcscan_pkg.sv
rtl/core/pcscan_unpack.sv
rtl/core/pcscan_outq.sv
rtl/core/packed_column_equality_scan_core.sv
sim/tb_top.sv
